// ===== sv/afmu_pkg.sv =====
// Package with the shared constants and types of the frequency model block.
`default_nettype none
package afmu_pkg;
  localparam int MAX_SYMBOLS_DEF = 256;
  localparam int COUNT_BITS_DEF = 15;
  localparam int LIMIT_CAP = 16'h3FFF;
  localparam int MAX_HALVINGS = 15;

  typedef enum logic [1:0] {
    FUNC_RESET  = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_SPARE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_SYMBOL_COUNT   = 2'd0,
    REG_ADAPTIVE_LIMIT = 2'd1,
    REG_LIMIT_WEIGHT   = 2'd2
  } reg_index_t;
endpackage
`default_nettype wire

// ===== sv/adaptive_freq_model_update.sv =====
// Top level of the adaptive frequency model: memory, sequencer and divider.
//
// Input transactions carry func and position on valid/ready; each gives one
// result transaction on the output channel, which holds until taken.
// The model state lies in one single-port memory indexed by rank, each word
// holding weight, cumulative count and symbol, with a registered read. A
// sequencer walks it one access per cycle, so the work done depends on func:
//   read (func 2 or 3) and out-of-range update: only the result reads.
//   model reset: one write per rank, then the result reads.
//   update at rank p: the tie scan, a tie swap if needed and the increment
//   pass, plus the adaptive limit division when enabled and one pass over
//   ranks symbol_count down to 0 for each halving.
// Only one transaction is in flight: input ready is high only while the
// sequencer is idle, and it rises the cycle after the result is taken.
// When the receiver stalls the result stays registered and no new input is
// taken. Reset (rst, synchronous) restores registers and then sweeps the
// memory to the reset model, one write per rank, before ready rises.
// Configuration writes take effect at once and also reload the live limit.
`default_nettype none
module adaptive_freq_model_update
  import afmu_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [8:0]  position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       entry_symbol,
  output logic [14:0]      entry_weight,
  output logic [14:0]      entry_cum_below,
  output logic [14:0]      total_count,
  output logic [8:0]       moved_position,
  output logic [3:0]       halvings
);
  localparam int NRANKS = MAX_SYMBOLS + 1;
  localparam int AW = $clog2(NRANKS);
  localparam int CB = COUNT_BITS;
  localparam int DB = CB + 3;

  typedef logic [CB-1:0] cnt_t;
  typedef logic [AW-1:0] addr_t;

  typedef struct packed {
    cnt_t       weight;
    cnt_t       cum;
    logic [7:0] sym;
  } rank_entry_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RD_REQ, S_RD_WAIT, S_RD_DONE,
    S_UP_RD, S_UP_CHK, S_SCAN_RD, S_SCAN_CHK, S_SWAP_RD, S_SWAP_WR,
    S_INC_RD, S_INC_WR, S_LIM_RD, S_LIM_DIV, S_HCHK,
    S_HALF_RD, S_HALF_WR, S_FIN, S_OUT
  } state_t;

  state_t state;

  logic [8:0] symbol_count;
  logic       adaptive_limit;
  logic [5:0] limit_weight;
  cnt_t       live_limit;

  rank_entry_t model_mem [NRANKS];

  logic       mem_we;
  addr_t      mem_addr;
  cnt_t       wr_weight, wr_cum;
  logic [7:0] wr_sym;
  logic       we_w, we_c, we_s;
  cnt_t       rd_weight, rd_cum;
  logic [7:0] rd_sym;

  always_ff @(posedge clk) begin
    if (mem_we && we_w) model_mem[mem_addr].weight <= wr_weight;
    if (mem_we && we_c) model_mem[mem_addr].cum <= wr_cum;
    if (mem_we && we_s) model_mem[mem_addr].sym <= wr_sym;
    rd_weight <= model_mem[mem_addr].weight;
    rd_cum    <= model_mem[mem_addr].cum;
    rd_sym    <= model_mem[mem_addr].sym;
  end

  // Working registers of the sequencer.
  logic [8:0] idx;
  logic [8:0] pos;
  logic [8:0] req_pos;
  logic [1:0] req_func;
  cnt_t       pos_weight;
  logic [7:0] pos_sym;
  logic [3:0] passes;
  logic [CB:0] acc;
  cnt_t       total;
  logic [4:0] div_cnt;
  logic [DB:0] rem;
  logic [DB-1:0] quo;
  logic [DB-1:0] divisor;
  logic       reinit_pending;

  logic [8:0]  sc_sat;
  logic [14:0] fixed_prod;
  always_comb begin
    sc_sat = cfg_data;
    if (cfg_data < 9'd2) sc_sat = 9'd2;
    if (cfg_data > 9'(MAX_SYMBOLS)) sc_sat = 9'(MAX_SYMBOLS);
  end

  logic [8:0] prod_sc;
  logic [5:0] prod_lw;
  always_comb begin
    prod_sc = symbol_count;
    prod_lw = limit_weight;
    if (cfg_index == REG_SYMBOL_COUNT) prod_sc = sc_sat;
    if (cfg_index == REG_LIMIT_WEIGHT) prod_lw = cfg_data[5:0];
    fixed_prod = 15'(prod_sc) * 15'(prod_lw);
  end

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    we_w = 1'b0;
    we_c = 1'b0;
    we_s = 1'b0;
    mem_addr = idx[AW-1:0];
    wr_weight = '0;
    wr_cum = '0;
    wr_sym = '0;
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
        we_w = 1'b1; we_c = 1'b1; we_s = 1'b1;
        wr_weight = (idx == 9'd0) ? cnt_t'(0) : cnt_t'(1);
        wr_cum = (idx <= symbol_count) ? cnt_t'(symbol_count - idx) : cnt_t'(0);
        wr_sym = (idx == 9'd0) ? 8'd0 : 8'(idx - 9'd1);
      end
      S_SWAP_WR: begin
        // The symbol of the lowest tying rank moves to the requested rank.
        mem_we = 1'b1; we_s = 1'b1;
        mem_addr = pos[AW-1:0];
        wr_sym = rd_sym;
      end
      S_INC_WR: begin
        mem_we = 1'b1; we_c = 1'b1;
        wr_cum = rd_cum + cnt_t'(1);
        if (idx == pos) begin
          we_w = 1'b1; we_s = 1'b1;
          wr_weight = rd_weight + cnt_t'(1);
          wr_sym = pos_sym;
          wr_cum = rd_cum;
        end
      end
      S_HALF_WR: begin
        mem_we = 1'b1; we_w = 1'b1; we_c = 1'b1;
        wr_weight = cnt_t'((CB+1)'(rd_weight) + 1'b1 >> 1);
        wr_cum = acc[CB-1:0];
      end
      S_SCAN_RD: mem_addr = AW'(idx - 9'd1);
      S_UP_RD: mem_addr = pos[AW-1:0];
      S_LIM_RD: mem_addr = symbol_count[AW-1:0];
      S_FIN: mem_addr = req_pos[AW-1:0];
      default: ;
    endcase
  end

  logic  [CB-1:0] lim_w;
  assign lim_w = (rd_weight == '0) ? cnt_t'(1) : rd_weight;

  logic [DB:0] rem_shift;
  assign rem_shift = {rem[DB-1:0], 1'b0} | (DB+1)'(quo[DB-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      in_ready <= 1'b0;
      out_valid <= 1'b0;
      reinit_pending <= 1'b0;
      symbol_count <= 9'd256;
      adaptive_limit <= 1'b0;
      limit_weight <= 6'd50;
      live_limit <= cnt_t'(256 * 50);
    end else begin
      if (cfg_we && (cfg_index inside {REG_SYMBOL_COUNT, REG_ADAPTIVE_LIMIT,
                                       REG_LIMIT_WEIGHT})) begin
        case (cfg_index)
          REG_SYMBOL_COUNT:   symbol_count <= sc_sat;
          REG_ADAPTIVE_LIMIT: adaptive_limit <= cfg_data[0];
          REG_LIMIT_WEIGHT:   limit_weight <= cfg_data[5:0];
          default: ;
        endcase
        live_limit <= cnt_t'(fixed_prod);
      end else if (state == S_LIM_DIV && div_cnt > 5'(DB)) begin
        live_limit <= (quo > DB'(LIMIT_CAP)) ? cnt_t'(LIMIT_CAP) : cnt_t'(quo);
      end
      case (state)
        S_INIT: begin
          if (idx == 9'(NRANKS - 1)) begin
            idx <= '0;
            state <= reinit_pending ? S_FIN : S_IDLE;
            in_ready <= !reinit_pending;
            reinit_pending <= 1'b0;
          end else begin
            idx <= idx + 9'd1;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            in_ready <= 1'b0;
            req_func <= func;
            req_pos <= position;
            pos <= position;
            passes <= '0;
            moved_position <= '0;
            if (func == FUNC_RESET) begin
              reinit_pending <= 1'b1;
              idx <= '0;
              state <= S_INIT;
            end else if (func == FUNC_UPDATE && position != 9'd0 &&
                         position <= symbol_count) begin
              state <= S_UP_RD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_UP_RD: state <= S_UP_CHK;
        S_UP_CHK: begin
          pos_weight <= rd_weight;
          pos_sym <= rd_sym;
          idx <= pos;
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          // Walk down while the rank above ties with the requested rank's weight.
          if (idx > 9'd1 && rd_weight == pos_weight) begin
            idx <= idx - 9'd1;
            state <= S_SCAN_RD;
          end else if (idx == pos) begin
            idx <= '0;
            state <= S_INC_RD;
          end else begin
            // idx is the lowest tying rank; pos still the original.
            state <= S_SWAP_RD;
          end
        end
        S_SWAP_RD: begin
          // Fetch the symbol at the lowest tying rank.
          state <= S_SWAP_WR;
        end
        S_SWAP_WR: begin
          pos <= idx;
          idx <= '0;
          state <= S_INC_RD;
        end
        S_INC_RD: state <= S_INC_WR;
        S_INC_WR: begin
          if (idx == pos) begin
            moved_position <= pos;
            state <= adaptive_limit ? S_LIM_RD : S_HCHK;
          end else begin
            idx <= idx + 9'd1;
            state <= S_INC_RD;
          end
          if (idx == 9'd0) total <= (pos == 9'd0) ? rd_cum : rd_cum + cnt_t'(1);
        end
        S_LIM_RD: begin
          div_cnt <= 5'd0;
          state <= S_LIM_DIV;
        end
        S_LIM_DIV: begin
          if (div_cnt == 5'd0) begin
            divisor <= DB'({lim_w, 1'b0} - 1'b1);
            quo <= DB'(((DB'({lim_w, 1'b0} - 1'b1)) >> 1) + DB'({total, 2'b00}));
            rem <= '0;
            div_cnt <= 5'd1;
          end else if (div_cnt <= 5'(DB)) begin
            if (rem_shift >= (DB+1)'(divisor)) begin
              rem <= rem_shift - (DB+1)'(divisor);
              quo <= {quo[DB-2:0], 1'b1};
            end else begin
              rem <= rem_shift;
              quo <= {quo[DB-2:0], 1'b0};
            end
            div_cnt <= div_cnt + 5'd1;
          end else begin
            state <= S_HCHK;
          end
        end
        S_HCHK: begin
          if (total > live_limit && passes != 4'(MAX_HALVINGS)) begin
            passes <= passes + 4'd1;
            acc <= '0;
            idx <= symbol_count;
            state <= S_HALF_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_HALF_RD: state <= S_HALF_WR;
        S_HALF_WR: begin
          acc <= acc + (CB+1)'(((CB+1)'(rd_weight) + 1'b1) >> 1);
          if (idx == 9'd0) begin
            total <= acc[CB-1:0];
            state <= S_HCHK;
          end else begin
            idx <= idx - 9'd1;
            state <= S_HALF_RD;
          end
        end
        S_FIN: begin
          idx <= '0;
          state <= S_RD_REQ;
        end
        S_RD_REQ: begin
          // Entry at the requested rank is now registered; fetch rank zero.
          entry_symbol <= rd_sym;
          entry_weight <= 15'(rd_weight);
          entry_cum_below <= 15'(rd_cum);
          if (req_pos > symbol_count) begin
            entry_symbol <= '0;
            entry_weight <= '0;
            entry_cum_below <= '0;
          end
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: state <= S_RD_DONE;
        S_RD_DONE: begin
          total_count <= 15'(rd_cum);
          halvings <= passes;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            in_ready <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{req_func, pos_weight[0]};
endmodule
`default_nettype wire
